FILE: sv/bohm_pkg.sv
// Shared types, codes and default sizes of the block offset hash map.
`default_nettype none
package bohm_pkg;

    localparam int unsigned KEY_W = 48;
    localparam int unsigned ID_W  = 24;

    localparam int unsigned DEF_BUCKETS     = 1024;
    localparam int unsigned DEF_WAYS        = 4;
    localparam int unsigned DEF_BLOCK_BYTES = 4096;

    localparam logic [1:0] KIND_LOOKUP = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_PRESENT = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key_offset;
        logic [ID_W-1:0]  buffer_id;
    } t_req;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] found_id;
    } t_rsp;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  id;
    } t_way;

endpackage
`default_nettype wire

FILE: sv/block_offset_hash_map.sv
// Top level of the block offset hash map: bucket row read-modify-write engine.
//
//   channel | valid   | stall   | word
//   --------+---------+---------+-------------------------------
//   request | i_valid | o_stall | i_req  (kind, key_offset, buffer_id)
//   result  | o_valid | i_stall | o_rsp  (status, found_id)
//
// Each request goes through a bucket row read, a way compare and a row write-back.
// The bucket row RAM has a single port, shared by the read and the write-back.
// After reset a clearing pass writes all BUCKETS rows, one per cycle, before
// the first request is taken.
// A result waits in the output register while the next request is read and
// compared; write-back holds until that register is free.
`default_nettype none
module block_offset_hash_map
    import bohm_pkg::*;
#(
    parameter int unsigned BUCKETS     = DEF_BUCKETS,
    parameter int unsigned WAYS        = DEF_WAYS,
    parameter int unsigned BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_req i_req,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_rsp      o_rsp
);

    localparam int unsigned BKT_W  = $clog2(BUCKETS);
    localparam int unsigned BLK_SH = $clog2(BLOCK_BYTES);
    localparam int unsigned ROW_W  = WAYS * $bits(t_way);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CMP,
        S_DONE
    } t_state;

    t_state r_state;

    logic [BKT_W-1:0] r_clr_idx;
    logic [BKT_W-1:0] r_bkt;
    logic [1:0]       r_kind;
    logic [KEY_W-1:0] r_key;
    logic [ID_W-1:0]  r_id;

    t_way [WAYS-1:0]  r_row;
    logic             r_we;
    t_rsp             r_res;

    logic             ram_en;
    logic             ram_we;
    logic [BKT_W-1:0] ram_addr;
    logic [ROW_W-1:0] ram_wdata;
    logic [ROW_W-1:0] ram_rdata;

    t_way [WAYS-1:0]  rd_row;
    t_way [WAYS-1:0]  n_row;
    logic [WAYS-1:0]  hit_oh;
    logic [WAYS-1:0]  free_oh;
    logic             any_hit;
    logic             any_free;
    logic [ID_W-1:0]  hit_id;
    logic             n_we;
    t_rsp             n_res;

    logic             accept;
    logic             out_free;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !o_valid || !i_stall;
    assign rd_row   = ram_rdata;

    bohm_ram #(
        .WIDTH(ROW_W),
        .DEPTH(BUCKETS)
    ) u_row_ram (
        .i_clk  (i_clk),
        .i_en   (ram_en),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        ram_en    = 1'b0;
        ram_we    = 1'b0;
        ram_addr  = r_bkt;
        ram_wdata = r_row;
        unique case (r_state)
            S_CLEAR: begin
                ram_en    = 1'b1;
                ram_we    = 1'b1;
                ram_addr  = r_clr_idx;
                ram_wdata = '0;
            end
            S_IDLE: begin
                ram_en   = accept;
                ram_addr = i_req.key_offset[BLK_SH +: BKT_W];
            end
            S_DONE: begin
                ram_en = r_we && out_free;
                ram_we = 1'b1;
            end
            default: begin
                ram_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        logic hit_taken;
        logic free_taken;
        hit_taken  = 1'b0;
        free_taken = 1'b0;
        hit_oh     = '0;
        free_oh    = '0;
        hit_id     = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (rd_row[w].valid) begin
                if (!hit_taken && rd_row[w].key == r_key) begin
                    hit_oh[w] = 1'b1;
                    hit_taken = 1'b1;
                end
            end else if (!free_taken) begin
                free_oh[w] = 1'b1;
                free_taken = 1'b1;
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            hit_id = hit_id | (hit_oh[w] ? rd_row[w].id : '0);
        end
        any_hit  = |hit_oh;
        any_free = |free_oh;
    end

    always_comb begin
        n_row          = rd_row;
        n_we           = 1'b0;
        n_res.status   = ST_MISS;
        n_res.found_id = '0;
        unique case (r_kind)
            KIND_LOOKUP: begin
                if (any_hit) begin
                    n_res.status   = ST_OK;
                    n_res.found_id = hit_id;
                end
            end
            KIND_INSERT: begin
                if (any_hit) begin
                    n_res.status   = ST_PRESENT;
                    n_res.found_id = hit_id;
                end else if (any_free) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (free_oh[w]) begin
                            n_row[w].valid = 1'b1;
                            n_row[w].key   = r_key;
                            n_row[w].id    = r_id;
                        end
                    end
                    n_we         = 1'b1;
                    n_res.status = ST_OK;
                end else begin
                    n_res.status = ST_FULL;
                end
            end
            KIND_DELETE: begin
                if (any_hit) begin
                    for (int w = 0; w < WAYS; w++) begin
                        if (hit_oh[w]) begin
                            n_row[w].valid = 1'b0;
                        end
                    end
                    n_we           = 1'b1;
                    n_res.status   = ST_OK;
                    n_res.found_id = hit_id;
                end
            end
            default: begin
                n_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            o_valid   <= 1'b0;
        end else begin
            if (o_valid && !i_stall && (r_state != S_DONE)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + BKT_W'(1);
                    if (r_clr_idx == BKT_W'(BUCKETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_bkt   <= i_req.key_offset[BLK_SH +: BKT_W];
                        r_kind  <= i_req.kind;
                        r_key   <= i_req.key_offset;
                        r_id    <= i_req.buffer_id;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_row   <= n_row;
                    r_we    <= n_we;
                    r_res   <= n_res;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_valid <= 1'b1;
                        o_rsp   <= r_res;
                        r_state <= S_IDLE;
                    end else begin
                        o_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: sv/bohm_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module bohm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                o_rdata <= r_mem[i_addr];
            end
        end
    end

endmodule
`default_nettype wire
